/* rtl/core/ohsw_pkg.sv */
// ----------------------------------------------------------------------------
// ohsw_pkg: shared types, constants and tables of the square wave synthesizer
// Holds the quarter-wave sine table, the harmonic reciprocals, the link
// between harmonic cells and the configuration register codes.
// ----------------------------------------------------------------------------
package ohsw_pkg;

	localparam int MAX_HARMONICS    = 15;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int PHASE_BITS       = 16;

	localparam int PHASE_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int COUNT_W   = 4;
	localparam int OUT_W     = 18;
	localparam int FS_FRAC   = 12;

	localparam int HIDX_W     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam int ROM_AW     = $clog2(SINE_TABLE_DEPTH);
	localparam int IDX_PROD_W = PHASE_BITS - 2 + ROM_AW;
	localparam int SINE_W     = 16;
	localparam int RECIP_W    = 17;
	localparam int TERM_W     = SINE_W + RECIP_W + 2;
	localparam int ACC_W      = 36;
	localparam int MAG_W      = ACC_W - 14;
	localparam int P1_W       = MAG_W + CFG_W;
	localparam int K_W        = 17;
	localparam int P2_W       = P1_W + K_W;
	localparam int Y_W        = P2_W - 31;

	localparam logic [K_W-1:0] FOUR_OVER_PI = 17'd83443;
	localparam int unsigned OUT_LIMIT = 2 ** (OUT_W - 1);
	localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(OUT_LIMIT - 1);
	localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(OUT_LIMIT);

	localparam int LATENCY = MAX_HARMONICS + 6;

	localparam logic [CFG_W-1:0]   AMPLITUDE_RST   = 16'd10240;
	localparam logic [CFG_W-1:0]   FREQ_SCALE_RST  = 16'd4096;
	localparam logic [COUNT_W-1:0] HARM_COUNT_RST  = 4'd15;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ROM_DIV = 4 * SINE_TABLE_DEPTH;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMPLITUDE  = 2'd0,
		CFG_FREQ_SCALE = 2'd1,
		CFG_HARM_COUNT = 2'd2
	} cfg_reg_e;

	typedef logic [SINE_TABLE_DEPTH-1:0][SINE_W-1:0] rom_t;
	typedef logic [MAX_HARMONICS-1:0][RECIP_W-1:0]   recip_t;

	typedef struct packed {
		logic                     valid;
		logic [PHASE_BITS-1:0]    scaled;
		logic [PHASE_BITS-1:0]    hp;
		logic signed [ACC_W-1:0]  acc;
		logic signed [TERM_W-1:0] term;
	} link_t;

	function automatic logic [SINE_W-1:0] rom_entry(input int unsigned k);
		longint unsigned kk;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint s;
		kk = 64'(k);
		x = (PI_Q30 * (2 * kk + 1)) / ROM_DIV;
		x2 = (x * x) >> 30;
		t = x;
		s = longint'(x);
		for (int i = 1; i <= 8; i++) begin
			t = (t * x2) >> 30;
			case (i)
				1: t = t / 6;
				2: t = t / 20;
				3: t = t / 42;
				4: t = t / 72;
				5: t = t / 110;
				6: t = t / 156;
				7: t = t / 210;
				default: t = t / 272;
			endcase
			if (i % 2 == 1) begin
				s = s - longint'(t);
			end else begin
				s = s + longint'(t);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		return SINE_W'((longint'(unsigned'(s)) * 32767 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			r[k] = rom_entry(k);
		end
		return r;
	endfunction

	// Rounded reciprocal of n in Q.16, found by restoring long division.
	function automatic logic [RECIP_W-1:0] recip_of(input int unsigned n);
		longint unsigned num;
		longint unsigned rem;
		longint unsigned q;
		num = 64'd65536 + 64'(n >> 1);
		rem = 0;
		q = 0;
		for (int b = RECIP_W; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			q = q << 1;
			if (rem >= 64'(n)) begin
				rem = rem - 64'(n);
				q = q | 64'd1;
			end
		end
		return RECIP_W'(q);
	endfunction

	function automatic recip_t build_recip();
		recip_t r;
		for (int h = 0; h < MAX_HARMONICS; h++) begin
			r[h] = recip_of(2 * h + 1);
		end
		return r;
	endfunction

	localparam rom_t   SINE_ROM    = build_rom();
	localparam recip_t RECIP_TABLE = build_recip();

endpackage

/* rtl/core/ohsw_cell.sv */
// ----------------------------------------------------------------------------
// ohsw_cell: one odd-harmonic cell of the synthesis chain
// Looks up the sine of its harmonic phase, weights it by the harmonic
// reciprocal, folds the previous cell's term into the running sum and
// advances the harmonic phase for the next cell.
// ----------------------------------------------------------------------------
module ohsw_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ohsw_pkg::HIDX_W-1:0]    harm_idx,
	input  logic [ohsw_pkg::COUNT_W-1:0]   harmonic_count,
	input  ohsw_pkg::link_t                link_in,
	output ohsw_pkg::link_t                link_out
);

	logic [1:0]                             quad;
	logic [ohsw_pkg::PHASE_BITS-3:0]        rem;
	logic [ohsw_pkg::IDX_PROD_W-1:0]        idx_prod;
	logic [ohsw_pkg::ROM_AW-1:0]            idx;
	logic [ohsw_pkg::ROM_AW-1:0]            rom_addr;
	logic [ohsw_pkg::SINE_W-1:0]            rom_data;
	logic signed [ohsw_pkg::SINE_W:0]       sine;
	logic signed [ohsw_pkg::RECIP_W:0]      recip;
	logic                                   active;
	ohsw_pkg::link_t                        link_d;
	ohsw_pkg::link_t                        link_q;

	always_comb begin
		quad = link_in.hp[ohsw_pkg::PHASE_BITS-1 -: 2];
		rem = link_in.hp[ohsw_pkg::PHASE_BITS-3:0];
		idx_prod = ohsw_pkg::IDX_PROD_W'(rem) *
			ohsw_pkg::IDX_PROD_W'(ohsw_pkg::SINE_TABLE_DEPTH);
		idx = idx_prod[ohsw_pkg::PHASE_BITS-2 +: ohsw_pkg::ROM_AW];
		rom_addr = quad[0] ?
			ohsw_pkg::ROM_AW'(ohsw_pkg::SINE_TABLE_DEPTH - 1) - idx : idx;
		rom_data = ohsw_pkg::SINE_ROM[rom_addr];
		sine = quad[1] ? -signed'({1'b0, rom_data}) : signed'({1'b0, rom_data});
		recip = signed'({1'b0, ohsw_pkg::RECIP_TABLE[harm_idx]});
		active = (8'(harm_idx) < 8'(harmonic_count));

		link_d.valid = link_in.valid;
		link_d.scaled = link_in.scaled;
		link_d.hp = link_in.hp + {link_in.scaled[ohsw_pkg::PHASE_BITS-2:0], 1'b0};
		link_d.acc = link_in.acc + ohsw_pkg::ACC_W'(link_in.term);
		link_d.term = active ?
			ohsw_pkg::TERM_W'(sine) * ohsw_pkg::TERM_W'(recip) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_d;
		end
	end

	assign link_out = link_q;

endmodule

/* rtl/core/ohsw_post.sv */
// ----------------------------------------------------------------------------
// ohsw_post: final sum, rounding, amplitude scaling and saturation
// Closes the harmonic sum, rounds it to Q.16, scales it by the amplitude and
// by 4/pi, rounds to Q10.8 and saturates to the output range.
// ----------------------------------------------------------------------------
module ohsw_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ohsw_pkg::link_t                     link_in,
	input  logic [ohsw_pkg::CFG_W-1:0]          amplitude,
	output logic                                done,
	output logic signed [ohsw_pkg::OUT_W-1:0]   sample_value
);

	localparam logic [ohsw_pkg::ACC_W:0] ACC_HALF = (ohsw_pkg::ACC_W + 1)'(1 << 14);
	localparam logic [ohsw_pkg::P2_W:0]  Y_HALF   = (ohsw_pkg::P2_W + 1)'(64'd1 << 31);

	logic                                 valid_s1;
	logic signed [ohsw_pkg::ACC_W-1:0]    acc_s1;
	logic                                 valid_s2;
	logic                                 neg_s2;
	logic [ohsw_pkg::MAG_W-1:0]           mag_s2;
	logic                                 valid_s3;
	logic                                 neg_s3;
	logic [ohsw_pkg::P1_W-1:0]            p1_s3;
	logic                                 valid_s4;
	logic                                 neg_s4;
	logic [ohsw_pkg::P2_W-1:0]            p2_s4;
	logic                                 done_q;
	logic signed [ohsw_pkg::OUT_W-1:0]    sample_q;

	logic [ohsw_pkg::ACC_W-1:0]           acc_abs;
	logic [ohsw_pkg::ACC_W:0]             acc_rnd;
	logic [ohsw_pkg::P2_W:0]              y_rnd;
	logic [ohsw_pkg::Y_W-1:0]             y_mag;
	logic signed [ohsw_pkg::OUT_W-1:0]    sample_d;

	always_comb begin
		acc_abs = acc_s1[ohsw_pkg::ACC_W-1] ? unsigned'(-acc_s1) : unsigned'(acc_s1);
		acc_rnd = {1'b0, acc_abs} + ACC_HALF;
		y_rnd = {1'b0, p2_s4} + Y_HALF;
		y_mag = y_rnd[ohsw_pkg::P2_W:32];
		if (!neg_s4) begin
			if (y_mag > ohsw_pkg::Y_W'(ohsw_pkg::OUT_LIMIT - 1)) begin
				sample_d = ohsw_pkg::OUT_MAX;
			end else begin
				sample_d = signed'(ohsw_pkg::OUT_W'(y_mag));
			end
		end else begin
			if (y_mag > ohsw_pkg::Y_W'(ohsw_pkg::OUT_LIMIT)) begin
				sample_d = ohsw_pkg::OUT_MIN;
			end else begin
				sample_d = -signed'(ohsw_pkg::OUT_W'(y_mag));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= link_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		acc_s1 <= link_in.acc + ohsw_pkg::ACC_W'(link_in.term);
		neg_s2 <= acc_s1[ohsw_pkg::ACC_W-1];
		mag_s2 <= acc_rnd[15 +: ohsw_pkg::MAG_W];
		neg_s3 <= neg_s2;
		p1_s3 <= ohsw_pkg::P1_W'(mag_s2) * ohsw_pkg::P1_W'(amplitude);
		neg_s4 <= neg_s3;
		p2_s4 <= ohsw_pkg::P2_W'(p1_s3) * ohsw_pkg::P2_W'(ohsw_pkg::FOUR_OVER_PI);
		sample_q <= sample_d;
	end

	assign done = done_q;
	assign sample_value = sample_q;

endmodule

/* rtl/core/odd_harmonic_square_wave_synth_core.sv */
// ----------------------------------------------------------------------------
// odd_harmonic_square_wave_synth_core: Fourier-series square wave synthesizer
// Turns a stream of phases into square wave samples built from the first
// odd harmonics of a sine.
// ----------------------------------------------------------------------------
// Usage:
// A phase beat is taken at every rising edge where start is high; busy is
// always low, so a new phase may be offered in every cycle.
// The phase is scaled by frequency_scale in one stage, then passes a row of
// MAX_HARMONICS cells, one per odd harmonic, each adding its weighted sine
// term to the running sum, then five stages of rounding, amplitude and 4/pi
// scaling and saturation.
// The result beat is on sample_value with done high for one cycle, after the
// input stage, the harmonic cells and the five post stages. Throughput is one
// sample per cycle; results leave in input order. Registers are written through
// cfg_we, cfg_index and cfg_data; an unknown index is ignored. The user must
// write them only while no sample is in flight; the block does not enforce it.
// Reset clears the pipeline valid bits and loads amplitude 40.0, frequency
// scale 1.0 and 15 harmonics. The receiver takes every result as it comes.
// ----------------------------------------------------------------------------
module odd_harmonic_square_wave_synth_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ohsw_pkg::PHASE_W-1:0]        phase,
	input  logic                                cfg_we,
	input  logic [ohsw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ohsw_pkg::CFG_W-1:0]          cfg_data,
	output logic                                done,
	output logic signed [ohsw_pkg::OUT_W-1:0]   sample_value
);

	localparam int SP_W = ohsw_pkg::PHASE_BITS + ohsw_pkg::CFG_W;

	logic [ohsw_pkg::CFG_W-1:0]         amplitude_q;
	logic [ohsw_pkg::CFG_W-1:0]         frequency_scale_q;
	logic [ohsw_pkg::COUNT_W-1:0]       harmonic_count_q;
	logic [SP_W-1:0]                    scale_prod;
	logic                               valid_s1;
	logic [ohsw_pkg::PHASE_BITS-1:0]    scaled_s1;
	ohsw_pkg::link_t                    chain [ohsw_pkg::MAX_HARMONICS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= ohsw_pkg::AMPLITUDE_RST;
			frequency_scale_q <= ohsw_pkg::FREQ_SCALE_RST;
			harmonic_count_q <= ohsw_pkg::HARM_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ohsw_pkg::CFG_AMPLITUDE: amplitude_q <= cfg_data;
				ohsw_pkg::CFG_FREQ_SCALE: frequency_scale_q <= cfg_data;
				ohsw_pkg::CFG_HARM_COUNT: harmonic_count_q <= cfg_data[ohsw_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	assign scale_prod = SP_W'(ohsw_pkg::PHASE_BITS'(phase)) * SP_W'(frequency_scale_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		scaled_s1 <= scale_prod[ohsw_pkg::FS_FRAC +: ohsw_pkg::PHASE_BITS];
	end

	always_comb begin
		chain[0].valid = valid_s1;
		chain[0].scaled = scaled_s1;
		chain[0].hp = scaled_s1;
		chain[0].acc = '0;
		chain[0].term = '0;
	end

	for (genvar g = 0; g < ohsw_pkg::MAX_HARMONICS; g++) begin : g_cell
		ohsw_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.harm_idx       (ohsw_pkg::HIDX_W'(g)),
			.harmonic_count (harmonic_count_q),
			.link_in        (chain[g]),
			.link_out       (chain[g+1])
		);
	end

	ohsw_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.link_in      (chain[ohsw_pkg::MAX_HARMONICS]),
		.amplitude    (amplitude_q),
		.done         (done),
		.sample_value (sample_value)
	);

endmodule

/* rtl/core/ohsw_checker.sv */
// ----------------------------------------------------------------------------
// ohsw_checker: port-level checks of the square wave synthesizer
// Watches the fixed latency between phase and result beats and the
// repeatability of back-to-back results.
// ----------------------------------------------------------------------------
module ohsw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [ohsw_pkg::PHASE_W-1:0]        phase,
	input logic                                done,
	input logic signed [ohsw_pkg::OUT_W-1:0]   sample_value
);

	localparam int LAT    = ohsw_pkg::LATENCY;
	localparam int WARM_W = $clog2(LAT + 2);

	logic [WARM_W-1:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q <= WARM_W'(LAT)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	a_beat_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q >= WARM_W'(LAT)) && $past(start && !busy, LAT) |-> done)
		else $error("Accepted phase beat gave no result beat.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q >= WARM_W'(LAT)) && !$past(start && !busy, LAT) |-> !done)
		else $error("Result beat without an accepted phase beat.");

	a_repeatable: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q > WARM_W'(LAT)) && done && $past(done) &&
		($past(phase, LAT) == $past(phase, LAT + 1)) |->
		sample_value == $past(sample_value))
		else $error("Equal back-to-back phases gave different samples.");

endmodule

bind odd_harmonic_square_wave_synth_core ohsw_checker u_checker (.*);

/* tb/odd_harmonic_square_wave_synth_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_harmonic_square_wave_synth_checker: sample predictor and scoreboard
// Follows register writes and accepted phase beats, computes each expected
// sample from its own quarter-wave sine table and harmonic sum, and compares
// every result beat with the oldest expected sample.
// ----------------------------------------------------------------------------
module odd_harmonic_square_wave_synth_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [ohsw_pkg::PHASE_W-1:0]        phase,
	input  logic                                cfg_we,
	input  logic [ohsw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ohsw_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                done,
	input  logic signed [ohsw_pkg::OUT_W-1:0]   sample_value,
	output int                                  errors,
	output int                                  pending
);

	localparam int TABLE_DEPTH = ohsw_pkg::SINE_TABLE_DEPTH;
	localparam int TURN_BITS = ohsw_pkg::PHASE_BITS;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint FOUR_OVER_PI_Q16 = 83443;
	localparam longint SAMPLE_MAX = 131071;
	localparam longint SAMPLE_MIN = -131072;

	logic [15:0] quarter_sine [TABLE_DEPTH];
	logic [ohsw_pkg::CFG_W-1:0] amplitude_q8_8;
	logic [ohsw_pkg::CFG_W-1:0] freq_scale_q4_12;
	logic [ohsw_pkg::COUNT_W-1:0] harmonics;
	logic signed [ohsw_pkg::OUT_W-1:0] expected_samples [$];
	logic signed [ohsw_pkg::OUT_W-1:0] oldest;

	function automatic logic [15:0] quarter_sine_value(input int k);
		longint unsigned kk;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		kk = k;
		x = (PI_Q30 * (2 * kk + 1)) / (4 * TABLE_DEPTH);
		x2 = (x * x) >> 30;
		term = x;
		s = x;
		for (int i = 1; i <= 8; i++) begin
			term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
			if (i % 2 == 1) begin
				s = s - longint'(term);
			end else begin
				s = s + longint'(term);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		return 16'(($unsigned(s) * 32767 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic longint round_away(input longint v, input int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (v < 0) begin
			return -((-v + half) >>> sh);
		end
		return (v + half) >>> sh;
	endfunction

	function automatic logic signed [ohsw_pkg::OUT_W-1:0] synth_sample(
		input logic [ohsw_pkg::PHASE_W-1:0] ph);
		longint unsigned mask;
		longint unsigned scaled;
		longint unsigned hp;
		longint unsigned quad;
		longint unsigned idx;
		longint unsigned n;
		longint sine;
		longint recip;
		longint acc;
		longint a16;
		longint y;
		int count;
		mask = (64'd1 << TURN_BITS) - 1;
		scaled = (((64'(ph) & mask) * 64'(freq_scale_q4_12)) >> 12) & mask;
		count = (harmonics > ohsw_pkg::MAX_HARMONICS) ? ohsw_pkg::MAX_HARMONICS : harmonics;
		acc = 0;
		for (int h = 0; h < count; h++) begin
			n = 2 * h + 1;
			hp = (scaled * n) & mask;
			quad = (hp >> (TURN_BITS - 2)) & 3;
			idx = ((hp & ((64'd1 << (TURN_BITS - 2)) - 1)) * TABLE_DEPTH) >> (TURN_BITS - 2);
			if (idx >= TABLE_DEPTH) begin
				idx = TABLE_DEPTH - 1;
			end
			if ((quad & 1) != 0) begin
				idx = TABLE_DEPTH - 1 - idx;
			end
			sine = quarter_sine[idx];
			if ((quad & 2) != 0) begin
				sine = -sine;
			end
			recip = (65536 + n / 2) / n;
			acc = acc + sine * recip;
		end
		a16 = round_away(acc, 15);
		y = round_away(a16 * longint'(amplitude_q8_8) * FOUR_OVER_PI_Q16, 32);
		if (y > SAMPLE_MAX) begin
			y = SAMPLE_MAX;
		end
		if (y < SAMPLE_MIN) begin
			y = SAMPLE_MIN;
		end
		return ohsw_pkg::OUT_W'(y);
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			quarter_sine[k] = quarter_sine_value(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q8_8 = ohsw_pkg::AMPLITUDE_RST;
			freq_scale_q4_12 = ohsw_pkg::FREQ_SCALE_RST;
			harmonics = ohsw_pkg::HARM_COUNT_RST;
			expected_samples.delete();
		end else begin
			if (done === 1'b1) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: sample_value mismatch, expected none, actual %0d",
						$time, sample_value);
					errors = errors + 1;
				end else begin
					oldest = expected_samples.pop_front();
					if (sample_value !== oldest) begin
						$display("%0t: sample_value mismatch, expected %0d, actual %0d",
							$time, oldest, sample_value);
						errors = errors + 1;
					end
				end
			end
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					ohsw_pkg::CFG_AMPLITUDE: begin
						amplitude_q8_8 = cfg_data;
					end
					ohsw_pkg::CFG_FREQ_SCALE: begin
						freq_scale_q4_12 = cfg_data;
					end
					ohsw_pkg::CFG_HARM_COUNT: begin
						harmonics = cfg_data[ohsw_pkg::COUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (start === 1'b1 && busy === 1'b0) begin
				expected_samples.insert(expected_samples.size(), synth_sample(phase));
			end
		end
		pending = expected_samples.size();
	end

endmodule

/* tb/odd_harmonic_square_wave_synth_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_harmonic_square_wave_synth_core_test: square wave synthesizer bench
// Drives phase beats with random gaps and bursts under a sequence of register
// settings, extremes included, while a checker predicts every sample.
// ----------------------------------------------------------------------------
module odd_harmonic_square_wave_synth_core_test;

	localparam logic [ohsw_pkg::CFG_IDX_W-1:0] UNUSED_REG = 2'd3;
	localparam int PHASE_TARGET = 1450;
	localparam int LONG_GAP_MAX = 60;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [ohsw_pkg::PHASE_W-1:0] phase;
	logic cfg_we;
	logic [ohsw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ohsw_pkg::CFG_W-1:0] cfg_data;
	logic done;
	logic signed [ohsw_pkg::OUT_W-1:0] sample_value;
	int errors;
	int pending;
	int phases_sent;

	odd_harmonic_square_wave_synth_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.phase(phase),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.sample_value(sample_value)
	);

	odd_harmonic_square_wave_synth_checker sample_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.phase(phase),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.sample_value(sample_value),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	task automatic write_reg(input logic [ohsw_pkg::CFG_IDX_W-1:0] idx,
		input logic [ohsw_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_phase(input logic [ohsw_pkg::PHASE_W-1:0] p, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		phase <= p;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		phases_sent = phases_sent + 1;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	function automatic int pick_gap(input bit bursty);
		int r;
		r = $urandom_range(0, 99);
		if (bursty || r < 60) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, LONG_GAP_MAX);
	endfunction

	function automatic logic [ohsw_pkg::PHASE_W-1:0] pick_phase();
		logic [ohsw_pkg::PHASE_W-1:0] p;
		p = 16'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			p = {2'($urandom_range(0, 3)), 14'h0};
			if ($urandom_range(0, 1) == 1) begin
				p = p - 1'b1;
			end
		end
		return p;
	endfunction

	initial begin
		logic [ohsw_pkg::CFG_W-1:0] amp;
		logic [ohsw_pkg::CFG_W-1:0] fscale;
		logic [ohsw_pkg::COUNT_W-1:0] count;
		int block;
		bit bursty;

		arst_n = 1'b0;
		start = 1'b0;
		phase = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		phases_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: quadrant edges and the ends of the phase range.
		send_phase(16'h0000, 0);
		send_phase(16'h0001, 0);
		send_phase(16'h3FFF, 0);
		send_phase(16'h4000, 0);
		send_phase(16'h4001, 0);
		send_phase(16'h7FFF, 0);
		send_phase(16'h8000, 0);
		send_phase(16'hC000, 0);
		send_phase(16'hFFFF, 0);
		send_phase(16'h2000, 0);
		wait_idle();

		// With no harmonics summed every sample is zero.
		write_reg(ohsw_pkg::CFG_HARM_COUNT, 16'h0000);
		send_phase(16'h4000, 0);
		send_phase(16'hC000, 0);
		wait_idle();

		write_reg(ohsw_pkg::CFG_HARM_COUNT, 16'h0001);
		write_reg(ohsw_pkg::CFG_AMPLITUDE, 16'hFFFF);
		write_reg(ohsw_pkg::CFG_FREQ_SCALE, 16'hFFFF);
		send_phase(16'h4000, 0);
		send_phase(16'hFFFF, 0);
		send_phase(16'h1234, 0);
		wait_idle();

		// A write to an unknown register must leave all settings alone.
		write_reg(UNUSED_REG, 16'hFFFF);
		write_reg(ohsw_pkg::CFG_FREQ_SCALE, 16'h0000);
		write_reg(ohsw_pkg::CFG_HARM_COUNT, 16'h000F);
		send_phase(16'hFFFF, 0);
		send_phase(16'hC000, 0);
		wait_idle();

		while (phases_sent < PHASE_TARGET) begin
			case ($urandom_range(0, 5))
				0: amp = 16'h0000;
				1: amp = 16'hFFFF;
				2: amp = ohsw_pkg::AMPLITUDE_RST;
				default: amp = 16'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: fscale = 16'h0000;
				1: fscale = 16'hFFFF;
				2: fscale = ohsw_pkg::FREQ_SCALE_RST;
				default: fscale = 16'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: count = 4'd0;
				1: count = 4'd1;
				2: count = 4'd15;
				default: count = 4'($urandom_range(0, 15));
			endcase
			write_reg(ohsw_pkg::CFG_AMPLITUDE, amp);
			write_reg(ohsw_pkg::CFG_FREQ_SCALE, fscale);
			write_reg(ohsw_pkg::CFG_HARM_COUNT, {12'($urandom), count});
			if ($urandom_range(0, 3) == 0) begin
				write_reg(UNUSED_REG, 16'($urandom));
			end
			block = $urandom_range(40, 160);
			if (block > PHASE_TARGET - phases_sent) begin
				block = PHASE_TARGET - phases_sent;
			end
			bursty = ($urandom_range(0, 3) == 0);
			repeat (block) send_phase(pick_phase(), pick_gap(bursty));
			wait_idle();
		end

		repeat (ohsw_pkg::LATENCY + 8) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ohsw_pkg.sv
rtl/core/ohsw_cell.sv
rtl/core/ohsw_post.sv
rtl/core/odd_harmonic_square_wave_synth_core.sv
rtl/core/ohsw_checker.sv
tb/odd_harmonic_square_wave_synth_checker.sv
tb/odd_harmonic_square_wave_synth_core_test.sv
